### sv/pcsp_pkg.sv
package pcsp_pkg;

    localparam int NUM_BINS   = 4096;
    localparam int BIN_IDX_W  = $clog2(NUM_BINS);
    localparam int COUNT_W    = 16;
    localparam int ENTRY_W    = COUNT_W + 1;
    localparam int TOTAL_W    = 32;
    localparam int TICK_W     = 16;
    localparam int PC_W       = 32;
    localparam int SHIFT_W    = 5;
    localparam int BIDX_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 168;

    localparam logic [PC_W-1:0]    LOW_PC_RST    = 32'h0800_2000;
    localparam logic [PC_W-1:0]    HIGH_PC_RST   = 32'h0800_f000;
    localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST = 5'd6;
    localparam logic [PC_W-1:0]    IDLE_PC_RST   = 32'h0000_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_START,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_PC,
        CFG_HIGH_PC,
        CFG_BIN_SHIFT,
        CFG_IDLE_PC
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

endpackage

### sv/pcsp_ram.sv
module pcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/pc_sampling_profiler.sv
// PC-sampling profiler. Each sample or command item is accepted in ST_IDLE,
// where its bin is read from the histogram memory, and finished in ST_EXEC,
// where the bin is written back once the output register is free; the result
// goes to an output register, so the next item can be accepted while it waits.
// The clear command walks every bin once in ST_CLEAR before ST_EXEC; after
// reset the same walk in ST_INIT holds off the first item. Configuration
// writes are always taken.
module pc_sampling_profiler
    import pcsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pc[31:0], tick[47:32], in_interrupt[48], task_running[49], bin_index[61:50]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted[0], bin_count[16:1], bin_missed[17], interrupt_total[49:18],
    // task_total[81:50], idle_total[113:82], other_total[145:114],
    // largest_gap[161:146]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    state_t state_reg, state_next;

    logic [PC_W-1:0]    low_pc_reg, high_pc_reg, idle_pc_reg;
    logic [SHIFT_W-1:0] bin_shift_reg;

    logic [TICK_W-1:0]  last_tick_reg, last_tick_next;
    logic [TOTAL_W-1:0] irq_tot_reg, irq_tot_next;
    logic [TOTAL_W-1:0] task_tot_reg, task_tot_next;
    logic [TOTAL_W-1:0] idle_tot_reg, idle_tot_next;
    logic [TOTAL_W-1:0] other_tot_reg, other_tot_next;
    logic [TICK_W-1:0]  max_gap_reg, max_gap_next;

    logic [BIN_IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    op_t                  op_reg, op_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 irq_reg, irq_next;
    logic                 task_reg, task_next;
    logic                 idle_hit_reg, idle_hit_next;
    logic                 hit_reg, hit_next;
    logic [BIN_IDX_W-1:0] addr_reg, addr_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    op_t                in_op;
    logic [PC_W-1:0]    in_pc;
    logic [TICK_W-1:0]  in_tick;
    logic               in_irq, in_task;
    logic [BIDX_W-1:0]  in_bidx;

    logic [PC_W-1:0]    pc_off, bin_full, addr_full;
    logic               in_win, bin_ok, read_ok;

    logic [TICK_W-1:0]  delta;
    logic               sample_do;
    logic [COUNT_W-1:0] bin_sum;
    logic               bin_miss;
    logic               out_free;

    logic                 ram_we, ram_re;
    logic [BIN_IDX_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_op   = op_t'(s_axis_tuser);
    assign in_pc   = s_axis_tdata[31:0];
    assign in_tick = s_axis_tdata[47:32];
    assign in_irq  = s_axis_tdata[48];
    assign in_task = s_axis_tdata[49];
    assign in_bidx = s_axis_tdata[61:50];

    assign pc_off    = in_pc - low_pc_reg;
    assign bin_full  = pc_off >> bin_shift_reg;
    assign in_win    = (in_pc >= low_pc_reg) && (in_pc < high_pc_reg);
    assign bin_ok    = bin_full < PC_W'(NUM_BINS);
    assign read_ok   = PC_W'(in_bidx) < PC_W'(NUM_BINS);
    assign addr_full = (in_op == OP_READ) ? PC_W'(in_bidx) : bin_full;

    assign delta     = tick_reg - last_tick_reg;
    assign sample_do = (op_reg == OP_SAMPLE) && hit_reg;
    assign bin_sum   = ram_rdata[COUNT_W-1:0] + delta;
    assign bin_miss  = ram_rdata[COUNT_W] | (delta > TICK_W'(1));
    assign out_free  = !m_valid_reg || m_axis_tready;

    pcsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (addr_full[BIN_IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        last_tick_next = last_tick_reg;
        irq_tot_next   = irq_tot_reg;
        task_tot_next  = task_tot_reg;
        idle_tot_next  = idle_tot_reg;
        other_tot_next = other_tot_reg;
        max_gap_next   = max_gap_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        tick_next      = tick_reg;
        irq_next       = irq_reg;
        task_next      = task_reg;
        idle_hit_next  = idle_hit_reg;
        hit_next       = hit_reg;
        addr_next      = addr_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        s_axis_tready  = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = {bin_miss, bin_sum};

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + BIN_IDX_W'(1);
                if (clr_cnt_reg == BIN_IDX_W'(NUM_BINS - 1)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_EXEC;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    ram_re        = 1'b1;
                    op_next       = in_op;
                    tick_next     = in_tick;
                    irq_next      = in_irq;
                    task_next     = in_task;
                    idle_hit_next = (in_pc == idle_pc_reg);
                    addr_next     = addr_full[BIN_IDX_W-1:0];
                    case (in_op)
                        OP_SAMPLE: hit_next = in_win && bin_ok;
                        OP_READ:   hit_next = read_ok;
                        default:   hit_next = 1'b0;
                    endcase
                    if (in_op == OP_CLEAR) begin
                        irq_tot_next   = '0;
                        task_tot_next  = '0;
                        idle_tot_next  = '0;
                        other_tot_next = '0;
                        max_gap_next   = '0;
                        clr_cnt_next   = '0;
                        state_next     = ST_CLEAR;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (sample_do) begin
                        ram_we = 1'b1;
                        if (irq_reg) begin
                            irq_tot_next = irq_tot_reg + TOTAL_W'(delta);
                        end else if (task_reg) begin
                            task_tot_next = task_tot_reg + TOTAL_W'(delta);
                        end else if (idle_hit_reg) begin
                            idle_tot_next = idle_tot_reg + TOTAL_W'(delta);
                        end else begin
                            other_tot_next = other_tot_reg + TOTAL_W'(delta);
                        end
                        if (delta > max_gap_reg) begin
                            max_gap_next = delta;
                        end
                        last_tick_next = tick_reg;
                    end
                    if (op_reg == OP_START) begin
                        last_tick_next = tick_reg;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {
                        6'b0,
                        max_gap_next,
                        other_tot_next,
                        idle_tot_next,
                        task_tot_next,
                        irq_tot_next,
                        (op_reg == OP_READ) && hit_reg && ram_rdata[COUNT_W],
                        ((op_reg == OP_READ) && hit_reg) ? ram_rdata[COUNT_W-1:0]
                                                         : COUNT_W'(0),
                        sample_do
                    };
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            last_tick_reg <= '0;
            irq_tot_reg   <= '0;
            task_tot_reg  <= '0;
            idle_tot_reg  <= '0;
            other_tot_reg <= '0;
            max_gap_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            m_valid_reg   <= m_valid_next;
            last_tick_reg <= last_tick_next;
            irq_tot_reg   <= irq_tot_next;
            task_tot_reg  <= task_tot_next;
            idle_tot_reg  <= idle_tot_next;
            other_tot_reg <= other_tot_next;
            max_gap_reg   <= max_gap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_pc_reg    <= LOW_PC_RST;
            high_pc_reg   <= HIGH_PC_RST;
            bin_shift_reg <= BIN_SHIFT_RST;
            idle_pc_reg   <= IDLE_PC_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_PC:    low_pc_reg    <= cfg_data;
                CFG_HIGH_PC:   high_pc_reg   <= cfg_data;
                CFG_BIN_SHIFT: bin_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_IDLE_PC:   idle_pc_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tick_reg     <= tick_next;
        irq_reg      <= irq_next;
        task_reg     <= task_next;
        idle_hit_reg <= idle_hit_next;
        hit_reg      <= hit_next;
        addr_reg     <= addr_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcsp_pkg::*;

    localparam longint CYCLE_LIMIT = 1_500_000;
    localparam int     SETTLE      = NUM_BINS + 16;

    typedef struct packed {
        logic                accepted;
        logic [COUNT_W-1:0]  bin_count;
        logic                bin_missed;
        logic [TOTAL_W-1:0]  interrupt_total;
        logic [TOTAL_W-1:0]  task_total;
        logic [TOTAL_W-1:0]  idle_total;
        logic [TOTAL_W-1:0]  other_total;
        logic [TICK_W-1:0]   largest_gap;
    } profile_report_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // predictor state
    logic [PC_W-1:0]    win_low   = LOW_PC_RST;
    logic [PC_W-1:0]    win_high  = HIGH_PC_RST;
    logic [SHIFT_W-1:0] win_shift = BIN_SHIFT_RST;
    logic [PC_W-1:0]    idle_addr = IDLE_PC_RST;
    logic [TICK_W-1:0]  prof_last_tick = '0;
    logic [COUNT_W-1:0] hist_bins [NUM_BINS];
    logic               hist_miss [NUM_BINS];
    logic [TOTAL_W-1:0] irq_ticks, task_ticks, idle_ticks, other_ticks;
    logic [TICK_W-1:0]  peak_gap;
    logic [BIDX_W-1:0]  recent_bin = '0;

    profile_report_t expected_reports[$];
    profile_report_t want;
    logic [M_TDATA_W-1:0] result_word;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_request  = 0;
    int     hold_left     = 0;
    int     clears_left   = 12;
    int     fail_count    = 0;
    longint cycle_count   = 0;

    pc_sampling_profiler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            result_word = m_axis_tdata;
            #1;
            if (expected_reports.size() == 0) begin
                $error("result item with nothing expected: %h", result_word);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("accepted",        32'(want.accepted),     32'(result_word[0]));
                check_field("bin_count",       32'(want.bin_count),    32'(result_word[16:1]));
                check_field("bin_missed",      32'(want.bin_missed),   32'(result_word[17]));
                check_field("interrupt_total", want.interrupt_total,   result_word[49:18]);
                check_field("task_total",      want.task_total,        result_word[81:50]);
                check_field("idle_total",      want.idle_total,        result_word[113:82]);
                check_field("other_total",     want.other_total,       result_word[145:114]);
                check_field("largest_gap",     32'(want.largest_gap),
                            32'(result_word[161:146]));
            end
        end
    end

    function automatic void clear_profile();
        foreach (hist_bins[i]) begin
            hist_bins[i] = '0;
            hist_miss[i] = 1'b0;
        end
        irq_ticks   = '0;
        task_ticks  = '0;
        idle_ticks  = '0;
        other_ticks = '0;
        peak_gap    = '0;
    endfunction

    function automatic profile_report_t predict_profile(op_t op, logic [PC_W-1:0] pc,
                                                        logic [TICK_W-1:0] tick, logic irq,
                                                        logic task_run,
                                                        logic [BIDX_W-1:0] bidx);
        profile_report_t r;
        logic [PC_W-1:0]   bin;
        logic [TICK_W-1:0] delta;
        r = '0;
        case (op)
            OP_SAMPLE: begin
                bin = (pc - win_low) >> win_shift;
                if (pc >= win_low && pc < win_high && bin < NUM_BINS) begin
                    delta = tick - prof_last_tick;
                    if (irq)
                        irq_ticks += TOTAL_W'(delta);
                    else if (task_run)
                        task_ticks += TOTAL_W'(delta);
                    else if (pc == idle_addr)
                        idle_ticks += TOTAL_W'(delta);
                    else
                        other_ticks += TOTAL_W'(delta);
                    hist_bins[bin[BIN_IDX_W-1:0]] = hist_bins[bin[BIN_IDX_W-1:0]] + delta;
                    if (delta > 1)
                        hist_miss[bin[BIN_IDX_W-1:0]] = 1'b1;
                    if (delta > peak_gap)
                        peak_gap = delta;
                    prof_last_tick = tick;
                    recent_bin = bin[BIDX_W-1:0];
                    r.accepted = 1'b1;
                end
            end
            OP_START: prof_last_tick = tick;
            OP_READ: begin
                r.bin_count  = hist_bins[bidx];
                r.bin_missed = hist_miss[bidx];
            end
            default: clear_profile();
        endcase
        r.interrupt_total = irq_ticks;
        r.task_total      = task_ticks;
        r.idle_total      = idle_ticks;
        r.other_total     = other_ticks;
        r.largest_gap     = peak_gap;
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [PC_W-1:0] pc,
                             input logic [TICK_W-1:0] tick, input logic irq,
                             input logic task_run, input logic [BIDX_W-1:0] bidx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, bidx, task_run, irq, tick, pc};
        do @(posedge aclk); while (!s_axis_tready);
        expected_reports.push_back(predict_profile(op, pc, tick, irq, task_run, bidx));
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_put(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LOW_PC:    win_low   = val;
            CFG_HIGH_PC:   win_high  = val;
            CFG_BIN_SHIFT: win_shift = val[SHIFT_W-1:0];
            default:       idle_addr = val;
        endcase
    endtask

    task automatic write_config(input logic [PC_W-1:0] low, input logic [PC_W-1:0] high,
                                input logic [SHIFT_W-1:0] shift, input logic [PC_W-1:0] idle);
        wait_results_done();
        // a clear may still be walking the bins
        repeat (SETTLE) @(posedge aclk);
        cfg_put(CFG_LOW_PC, low);
        cfg_put(CFG_HIGH_PC, high);
        cfg_put(CFG_BIN_SHIFT, 32'(shift));
        cfg_put(CFG_IDLE_PC, idle);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PC_W-1:0] pick_pc();
        logic [32:0] span;
        logic [63:0] reach;
        logic [63:0] off;
        int r;
        r = $urandom_range(99);
        span = (win_high > win_low) ? {1'b0, win_high} - {1'b0, win_low} : 33'd0;
        reach = 64'(NUM_BINS) << win_shift;
        if (reach > 64'(span))
            reach = 64'(span);
        if (r < 10 || span == 0)
            return $urandom;
        if (r < 16)
            return idle_addr;
        if (r < 19)
            return win_low - 1;
        if (r < 22)
            return win_high;
        if (r < 25)
            return win_low + reach[31:0];
        off = {$urandom, $urandom} % reach;
        return win_low + off[31:0];
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        if ($urandom_range(99) < 75)
            return prof_last_tick + TICK_W'($urandom_range(3));
        return TICK_W'($urandom);
    endfunction

    task automatic run_random(input int count);
        op_t op;
        int r;
        logic [BIDX_W-1:0] bidx;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(999);
            if (r < 4) begin
                op = (clears_left > 0) ? OP_CLEAR : OP_READ;
                if (clears_left > 0)
                    clears_left--;
            end else if (r < 620) begin
                op = OP_SAMPLE;
            end else if (r < 700) begin
                op = OP_START;
            end else begin
                op = OP_READ;
            end
            bidx = $urandom_range(1) ? recent_bin : BIDX_W'($urandom);
            send_item(op, pick_pc(), pick_tick(), $urandom_range(3) == 0,
                      1'($urandom_range(1)), bidx);
        end
    endtask

    task automatic test_reset_config();
        send_item(OP_READ,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 12'h000);
        send_item(OP_START,  32'h0000_0000, 16'hFFFF, 1'b0, 1'b0, 12'hFFF);
        send_item(OP_SAMPLE, LOW_PC_RST,    16'h0001, 1'b1, 1'b1, 12'h000);
        send_item(OP_SAMPLE, HIGH_PC_RST-1, 16'h0001, 1'b0, 1'b1, 12'h000);
        send_item(OP_SAMPLE, HIGH_PC_RST,   16'h1234, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, LOW_PC_RST-1,  16'h1234, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, LOW_PC_RST+64, 16'h0002, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, LOW_PC_RST,    16'h0001, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_0000, 16'h0050, 1'b0, 1'b0, 12'h000);
        send_item(OP_READ,   32'h0000_0000, 16'h0000, 1'b0, 1'b0, 12'h000);
        send_item(OP_READ,   32'h0000_0000, 16'h0000, 1'b0, 1'b0, 12'h33F);
        send_item(OP_READ,   32'h0000_0000, 16'h0000, 1'b0, 1'b0, 12'h001);
        send_item(OP_READ,   32'h0000_0000, 16'h0000, 1'b0, 1'b0, 12'hFFF);
        send_item(OP_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 12'hFFF);
        send_item(OP_READ,   32'h0000_0000, 16'h0000, 1'b0, 1'b0, 12'h000);
        // clear keeps the last tick
        send_item(OP_SAMPLE, LOW_PC_RST+128, 16'h0003, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, 1'b1, 12'hFFF);
        send_item(OP_START,  32'hFFFF_FFFF,  16'h0000, 1'b1, 1'b1, 12'hFFF);
        send_item(OP_SAMPLE, LOW_PC_RST+128, 16'hFFFF, 1'b0, 1'b1, 12'h000);
        send_item(OP_READ,   32'h0000_0000,  16'h0000, 1'b0, 1'b0, 12'h002);
    endtask

    task automatic test_idle_attribution();
        write_config(32'h0000_1000, 32'h0000_2000, 5'd0, 32'h0000_1800);
        send_item(OP_START,  32'h0, 16'h0100, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_1800, 16'h0105, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_1800, 16'h0107, 1'b0, 1'b1, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_1800, 16'h010A, 1'b1, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_1FFF, 16'h010B, 1'b0, 1'b0, 12'h000);
        send_item(OP_READ,   32'h0, 16'h0000, 1'b0, 1'b0, 12'h800);
        send_item(OP_READ,   32'h0, 16'h0000, 1'b0, 1'b0, 12'hFFF);
    endtask

    task automatic test_window_extremes();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        write_config(32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFE);
        send_item(OP_SAMPLE, 32'h0000_0FFF, 16'h0000, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h0000_1000, 16'h0004, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'hFFFF_FFFE, 16'h0005, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, 16'h0006, 1'b0, 1'b0, 12'h000);
        send_item(OP_READ,   32'h0, 16'h0000, 1'b0, 1'b0, 12'hFFF);
        run_random(40);
        write_config(32'h0000_0000, 32'hFFFF_FFFF, 5'd31, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'h7FFF_FFFF, 16'h0100, 1'b0, 1'b0, 12'h000);
        send_item(OP_SAMPLE, 32'h8000_0000, 16'h0103, 1'b0, 1'b0, 12'h000);
        send_item(OP_READ,   32'h0, 16'h0000, 1'b0, 1'b0, 12'h001);
        run_random(40);
        write_config(32'h0000_2000, 32'h0000_1000, 5'd4, 32'h0000_1800);
        run_random(30);
        write_config(32'h0000_5000, 32'h0000_5000, 5'd2, 32'h0000_5000);
        send_item(OP_SAMPLE, 32'h0000_5000, 16'hABCD, 1'b0, 1'b0, 12'h000);
        run_random(30);
    endtask

    task automatic test_backpressure();
        logic [PC_W-1:0] low;
        low = $urandom & 32'hFFF0_0000;
        write_config(low, low + 32'h0001_0000, 5'd5, low + 32'h40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 400;
        run_random(30);
        wait_results_done();
        run_random(30);
    endtask

    task automatic test_random_traffic();
        logic [PC_W-1:0] low;
        low = $urandom & 32'hFFFF_F000;
        write_config(low, low + 32'($urandom_range(32'h100, 32'h4_0000)),
                     SHIFT_W'($urandom_range(8)), low + 32'($urandom_range(255) & 252));
        send_idle_pct = 13;
        recv_idle_pct = 69;
        run_random(500);
        write_config(32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 32'($urandom_range(4095)));
        send_idle_pct = 69;
        recv_idle_pct = 13;
        run_random(500);
        write_config(32'h0800_0000, 32'h0804_0000, 5'd6, 32'h0800_0100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(500);
    endtask

    initial begin
        clear_profile();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config();
        test_idle_attribution();
        test_window_extremes();
        test_backpressure();
        test_random_traffic();
        wait_results_done();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
